@@ src/bdpl_pkg.sv @@
// Shared types, constants and helpers for the button debounce / press length unit.
// No dependencies; every other file refers to this package by scoped names.
package bdpl_pkg;

   localparam int TimeWidth = 32;
   localparam int CmpWidth = (TimeWidth > 32) ? TimeWidth : 32;
   localparam int CsrIndexWidth = 8;

   localparam logic [15:0] HistForce = 16'hE000;
   localparam logic [15:0] HistDone = 16'hF000;

   typedef logic [TimeWidth-1:0] time_type;

   typedef enum logic [CsrIndexWidth-1:0] {
      CSR_HOLD_TWO   = 8'd0,
      CSR_HOLD_FOUR  = 8'd1,
      CSR_HOLD_EIGHT = 8'd2
   } csr_index_type;

   typedef enum logic [1:0] {
      CLASS_SHORT = 2'd0,
      CLASS_TWO   = 2'd1,
      CLASS_FOUR  = 2'd2,
      CLASS_EIGHT = 2'd3
   } press_class_type;

   typedef struct packed {
      logic [31:0] hold_two;
      logic [31:0] hold_four;
      logic [31:0] hold_eight;
   } thresholds_type;

   typedef struct packed {
      logic        pin_level;
      logic [31:0] now_ticks;
      logic        check_strobe;
   } step_type;

   // Widen elapsed time and a threshold to a common width before comparing.
   function automatic logic reached(time_type held, logic [31:0] thr);
      logic [CmpWidth-1:0] h;
      logic [CmpWidth-1:0] t;
      h = CmpWidth'(held);
      t = CmpWidth'(thr);
      return h >= t;
   endfunction

   // Eight-second threshold tested first, then downward.
   function automatic press_class_type classify(time_type held, thresholds_type thr);
      press_class_type c;
      if (reached(held, thr.hold_eight)) c = CLASS_EIGHT;
      else if (reached(held, thr.hold_four)) c = CLASS_FOUR;
      else if (reached(held, thr.hold_two)) c = CLASS_TWO;
      else c = CLASS_SHORT;
      return c;
   endfunction

endpackage

@@ src/bdpl_if.sv @@
// Channel interfaces for the press length unit: request, response and CSR write.
// Depends on bdpl_pkg for the CSR index width.
interface bdpl_req_if;
   logic        valid;
   logic        ready;
   logic        pin_level;
   logic [31:0] now_ticks;
   logic        check_strobe;
   modport source (output valid, pin_level, now_ticks, check_strobe, input ready);
   modport sink (input valid, pin_level, now_ticks, check_strobe, output ready);
endinterface

interface bdpl_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  press_class;
   logic [31:0] held_ticks;
   modport source (output valid, press_class, held_ticks, input ready);
   modport sink (input valid, press_class, held_ticks, output ready);
endinterface

interface bdpl_csr_if;
   logic                                valid;
   logic                                ready;
   logic [bdpl_pkg::CsrIndexWidth-1:0]  index;
   logic [31:0]                         data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

@@ src/bdpl_csr.sv @@
// Threshold registers for the press length unit, written through the CSR channel.
// Depends on bdpl_pkg and bdpl_if.
module bdpl_csr (
   input  logic                     clock,
   input  logic                     reset,
   bdpl_csr_if.sink                 csr,
   output bdpl_pkg::thresholds_type thr
);

   bdpl_pkg::thresholds_type thr_ff, thr_in;

   assign csr.ready = 1'b1;

   always_comb begin
      thr_in = thr_ff;
      if (csr.valid) begin
         unique case (csr.index)
            bdpl_pkg::CSR_HOLD_TWO:   thr_in.hold_two = csr.data;
            bdpl_pkg::CSR_HOLD_FOUR:  thr_in.hold_four = csr.data;
            bdpl_pkg::CSR_HOLD_EIGHT: thr_in.hold_eight = csr.data;
            default: ; // unmapped index, write dropped
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff.hold_two <= 32'd65536;
         thr_ff.hold_four <= 32'd131072;
         thr_ff.hold_eight <= 32'd262144;
      end else begin
         thr_ff <= thr_in;
      end
   end

   assign thr = thr_ff;

endmodule

@@ src/bdpl_core.sv @@
// Debounce state, press timing and the result register of the press length unit.
// Depends on bdpl_pkg and bdpl_if.
module bdpl_core (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     step_valid,
   input  bdpl_pkg::step_type       step,
   output logic                     step_take,
   input  bdpl_pkg::thresholds_type thr,
   bdpl_rsp_if.source               rsp
);

   logic                 armed_ff, armed_in;
   logic                 reported_ff, reported_in;
   bdpl_pkg::time_type   start_ff, start_in;
   logic [15:0]          history_ff, history_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [1:0]           class_ff, class_in;
   logic [31:0]          held_ff, held_in;

   logic                 fire;
   logic                 pressed;
   logic                 emit;
   bdpl_pkg::time_type   now_t;
   bdpl_pkg::time_type   held;
   logic [15:0]          hist_next;

   // The held step moves on when the result slot is free or being drained.
   assign fire = step_valid && (!rsp_valid_ff || rsp.ready);
   assign step_take = fire;

   assign pressed = !step.pin_level;
   assign now_t = bdpl_pkg::TimeWidth'(step.now_ticks);
   assign held = now_t - start_ff;
   assign hist_next = {history_ff[14:0], pressed} | bdpl_pkg::HistForce;

   always_comb begin
      armed_in = armed_ff;
      reported_in = reported_ff;
      start_in = start_ff;
      history_in = history_ff;
      emit = 1'b0;
      if (fire) begin
         if (!armed_ff) begin
            if (pressed) begin
               armed_in = 1'b1;
               start_in = now_t;
            end
         end else if (step.check_strobe) begin
            history_in = hist_next;
            if (hist_next == bdpl_pkg::HistDone) begin
               armed_in = 1'b0;
               reported_in = 1'b0;
               start_in = '0;
               emit = !reported_ff;
            end else if (!reported_ff && pressed &&
                         bdpl_pkg::reached(held, thr.hold_eight)) begin
               // early report while still held; release report suppressed
               reported_in = 1'b1;
               emit = 1'b1;
            end
         end
      end
   end

   always_comb begin
      rsp_valid_in = fire ? emit : (rsp_valid_ff && !rsp.ready);
      class_in = class_ff;
      held_in = held_ff;
      if (emit) begin
         class_in = bdpl_pkg::classify(held, thr);
         held_in = 32'(held);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         armed_ff <= 1'b0;
         reported_ff <= 1'b0;
         start_ff <= '0;
         history_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         armed_ff <= armed_in;
         reported_ff <= reported_in;
         start_ff <= start_in;
         history_ff <= history_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      class_ff <= class_in;
      held_ff <= held_in;
   end

   assign rsp.valid = rsp_valid_ff;
   assign rsp.press_class = class_ff;
   assign rsp.held_ticks = held_ff;

   a_reported_needs_armed: assert property (@(posedge clock) disable iff (reset)
      reported_ff |-> armed_ff)
      else $error("early-report flag set while idle");

   a_history_forced: assert property (@(posedge clock) disable iff (reset)
      (history_ff == 16'h0000) || (history_ff[15:13] == 3'b111))
      else $error("history lost its forced top bits");

   a_rsp_from_fire: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(fire))
      else $error("response appeared without a processed request");

   a_disarm_on_done: assert property (@(posedge clock) disable iff (reset)
      (fire && armed_ff && step.check_strobe && hist_next == bdpl_pkg::HistDone)
      |=> (!armed_ff && !reported_ff && start_ff == '0))
      else $error("release not taken back to idle");

endmodule

@@ src/button_debounce_press_length_unit.sv @@
// Button debounce with press length classification.
//
// req: one request per time step: raw active-low pin level, free-running
//   timestamp and the periodic debounce check strobe.
// rsp: at most one result per request: press class (short, two, four,
//   eight seconds) and ticks held since the press was first sensed.
// csr: writes the three hold thresholds (index 0, 1, 2); other indexes are
//   dropped. Always ready; write only while no request is in flight.
//
// A request is captured in an input register, then evaluated against the
// debounce state and loaded into the result register, so a result is valid
// once its request has passed both registers. Throughput is one request
// per cycle while rsp does not stall; when it stalls, the result register
// holds, one more request waits in the input register and req.ready drops
// until the result is taken.
// Reset clears the state (idle, empty history) and the result valid flag and
// restores the default thresholds.
module button_debounce_press_length_unit (
   input logic        clock,
   input logic        reset,
   bdpl_req_if.sink   req,
   bdpl_rsp_if.source rsp,
   bdpl_csr_if.sink   csr
);

   logic                     step_valid_ff, step_valid_in;
   bdpl_pkg::step_type       step_ff, step_in;
   logic                     step_take;
   bdpl_pkg::thresholds_type thr;

   assign req.ready = !step_valid_ff || step_take;

   always_comb begin
      step_valid_in = req.ready ? req.valid : step_valid_ff;
      step_in = step_ff;
      if (req.valid && req.ready) begin
         step_in.pin_level = req.pin_level;
         step_in.now_ticks = req.now_ticks;
         step_in.check_strobe = req.check_strobe;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_valid_ff <= 1'b0;
      end else begin
         step_valid_ff <= step_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff <= step_in;
   end

   bdpl_csr u_csr (
      .clock (clock),
      .reset (reset),
      .csr   (csr),
      .thr   (thr)
   );

   bdpl_core u_core (
      .clock      (clock),
      .reset      (reset),
      .step_valid (step_valid_ff),
      .step       (step_ff),
      .step_take  (step_take),
      .thr        (thr),
      .rsp        (rsp)
   );

endmodule
